// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising aclk edge outside reset
`define IRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen outside reset
`define IRS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/irs_pkg.sv -----
`timescale 1ns / 1ps
// types, constants and gf(256) helpers for the interleaved rs encoder
package irs_pkg;

    localparam int MAX_DEPTH   = 8;
    localparam int MAX_PARITY  = 32;
    localparam int LANE_W      = $clog2(MAX_DEPTH);
    localparam int PIDX_W      = $clog2(MAX_PARITY);
    localparam int NPAR_E8     = 16;
    localparam int NPAR_E16    = 32;
    localparam int DCOUNT_W    = 11;
    localparam int DRAIN_W     = 8;
    localparam int TOTAL_W     = 9;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CODE_N      = 255;
    localparam int ROOT_STEP   = 11;
    localparam int ROOT_CENTER = 128;

    localparam logic [8:0]          FIELD_POLY = 9'h187;
    localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = {DCOUNT_W{1'b1}};

    // input item kinds
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 4'd1;

    typedef logic [7:0] sym_t;
    typedef logic [MAX_PARITY-1:0][7:0] coef_row_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_NOT_MULT = 2'd2,
        ERR_EMPTY    = 2'd3
    } err_t;

    // control handed to every cell of the parity chain
    typedef struct packed {
        logic              upd;
        logic              clr;
        logic [LANE_W-1:0] lane;
    } cell_ctrl_t;

    // one result item
    typedef struct packed {
        sym_t out_byte;
        logic is_parity;
        logic block_end;
        err_t error_code;
    } result_t;

    // gf(256) multiply, shift-and-add over the field polynomial
    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [8:0] aa;
        sym_t       r;
        aa = {1'b0, a};
        r  = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ aa[7:0];
            aa = {aa[7:0], 1'b0};
            if (aa[8]) aa = aa ^ FIELD_POLY;
        end
        return r;
    endfunction

    // alpha^k, elaboration use only
    function automatic sym_t gf_pow_alpha(input int k);
        sym_t r;
        int   e;
        r = 8'd1;
        e = k % CODE_N;
        for (int i = 0; i < e; i++) r = gf_mul(r, 8'd2);
        return r;
    endfunction

    // generator coefficients in cell order: cell j gets g[n-1-j]
    function automatic coef_row_t build_coef(input int n);
        sym_t      g [MAX_PARITY+1];
        sym_t      r;
        int        first;
        coef_row_t c;
        for (int k = 0; k <= MAX_PARITY; k++) g[k] = '0;
        g[0]  = 8'd1;
        first = ROOT_CENTER - n / 2;
        for (int i = 0; i < n; i++) begin
            r = gf_pow_alpha(ROOT_STEP * (first + i));
            for (int k = i + 1; k >= 1; k--) g[k] = g[k-1] ^ gf_mul(g[k], r);
            g[0] = gf_mul(g[0], r);
        end
        c = '0;
        for (int j = 0; j < n; j++) c[j] = g[n-1-j];
        return c;
    endfunction

    localparam coef_row_t COEF_E8  = build_coef(NPAR_E8);
    localparam coef_row_t COEF_E16 = build_coef(NPAR_E16);

    // data bytes allowed per frame: depth * (255 - parity count)
    function automatic logic [DCOUNT_W-1:0] frame_limit(input logic [3:0] depth,
                                                        input logic       mode);
        logic [7:0]  k;
        logic [11:0] p;
        k = mode ? 8'(CODE_N - NPAR_E16) : 8'(CODE_N - NPAR_E8);
        p = {8'b0, depth} * {4'b0, k};
        return p[DCOUNT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/irs_cell.sv -----
`timescale 1ns / 1ps
// one parity position of the lfsr chain, holding that byte for every lane
module irs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  irs_pkg::cell_ctrl_t  ctrl,
    input  logic                 en,
    input  irs_pkg::sym_t        fb,
    input  irs_pkg::sym_t        coef,
    input  irs_pkg::sym_t        nbr,
    output irs_pkg::sym_t        rd
);

    irs_pkg::sym_t lane_reg [irs_pkg::MAX_DEPTH];
    irs_pkg::sym_t val_next;

    // byte of the selected lane, seen by the left neighbor and the drain mux
    assign rd = lane_reg[ctrl.lane];

    // shifted-in neighbor byte plus feedback term; a fresh frame sees zeros
    assign val_next = (ctrl.clr ? 8'h00 : nbr) ^ irs_pkg::gf_mul(fb, coef);

    // selected lane takes the update, lanes not taking an update clear while clr is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < irs_pkg::MAX_DEPTH; i++) lane_reg[i] <= '0;
        end else begin
            for (int i = 0; i < irs_pkg::MAX_DEPTH; i++) begin
                if (ctrl.upd && en && (int'(ctrl.lane) == i)) begin
                    lane_reg[i] <= val_next;
                end else if (ctrl.clr) begin
                    lane_reg[i] <= '0;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/irs_outbuf.sv -----
`timescale 1ns / 1ps
// output register with skid stage for result items
module irs_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  irs_pkg::result_t  in_res,
    output logic              in_ready,
    output logic              out_valid,
    output irs_pkg::result_t  out_res,
    input  logic              out_ready
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    irs_pkg::result_t out_res_reg;
    irs_pkg::result_t skid_res_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // control: output stage refills from skid first, then from a new item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end else if (push) begin
            skid_res_reg <= in_res;
        end
    end

endmodule

// ----- hw/rtl/interleaved_rs_encoder.sv -----
`timescale 1ns / 1ps
// interleaved shortened reed-solomon encoder, top level
//
//   channel   direction   fields (tdata / tuser / tlast)
//   s_        in          data_byte[7:0] / mode / frame_end
//   m_        out         out_byte[7:0], error_code[9:8] / is_parity / block_end
//   cfg_      in          cfg_index 0 parity_mode, 1 interleave_depth; cfg_data
//
// one item per cycle in while s_tready is high, its result registered in the output stage; the 32-cell parity chain
// updates one lane per data byte, and a pull reads one cell of one lane.
// s_tready drops only while both the output register and the skid stage are full.
// reset is synchronous; all parity bytes clear in the reset cycle itself.
// cfg_ready is always high; writes take effect on the next item.
`include "assert_macros.svh"

module interleaved_rs_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] error_code, rest zero
    output logic [0:0]  m_tuser,   // [0] is_parity
    output logic        m_tlast,   // block_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [irs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = irs_pkg::LANE_W;
    localparam int ND = irs_pkg::MAX_DEPTH;
    localparam int NP = irs_pkg::MAX_PARITY;

    // configuration
    logic       parity_mode_reg;
    logic [3:0] depth_cfg_reg;

    // frame state
    logic [LW-1:0]                 lane_index_reg, lane_index_next;
    logic [irs_pkg::DCOUNT_W-1:0]  data_count_reg, data_count_next;
    logic [irs_pkg::DRAIN_W-1:0]   drain_count_reg, drain_count_next;
    logic                          draining_reg, draining_next;
    logic [LW-1:0]                 dc_r_reg [ND];
    logic [LW-1:0]                 dc_r_next [ND];
    logic [LW-1:0]                 dr_r_reg [ND];
    logic [LW-1:0]                 dr_r_next [ND];
    logic [irs_pkg::DRAIN_W-1:0]   dr_q_reg [ND];
    logic [irs_pkg::DRAIN_W-1:0]   dr_q_next [ND];

    logic                          acc, is_pull, data_acc, pull_acc, fresh;
    logic [3:0]                    depth_eff;
    logic [LW-1:0]                 dsel;
    logic [irs_pkg::PIDX_W-1:0]    npar_m1;
    logic [irs_pkg::TOTAL_W-1:0]   total;
    logic [LW-1:0]                 lane_cur, lane_nxt_val;
    logic [3:0]                    lane_inc;
    logic [irs_pkg::DCOUNT_W-1:0]  dcount_base, dcount_new;
    logic [LW-1:0]                 dc_r_new [ND];
    logic [LW-1:0]                 dc_base;
    logic                          too_long, not_mult;
    logic                          sat, last;
    logic [irs_pkg::TOTAL_W-1:0]   drain_ext;
    logic [LW-1:0]                 rd_lane;
    logic [irs_pkg::PIDX_W-1:0]    rd_j;
    irs_pkg::err_t                 data_err;

    irs_pkg::cell_ctrl_t           cell_ctrl;
    irs_pkg::sym_t                 cell_rd   [NP];
    irs_pkg::sym_t                 cell_nbr  [NP];
    irs_pkg::sym_t                 cell_coef [NP];
    logic [NP-1:0]                 cell_en;
    irs_pkg::sym_t                 fb;

    irs_pkg::result_t              res_in, res_out;

    assign cfg_ready = 1'b1;

    // effective depth and parity geometry
    always_comb begin
        if (depth_cfg_reg == 4'd0) begin
            depth_eff = 4'd1;
        end else if (depth_cfg_reg > 4'(ND)) begin
            depth_eff = 4'(ND);
        end else begin
            depth_eff = depth_cfg_reg;
        end
    end
    assign dsel    = LW'(depth_eff - 4'd1);
    assign npar_m1 = parity_mode_reg ? irs_pkg::PIDX_W'(irs_pkg::NPAR_E16 - 1)
                                     : irs_pkg::PIDX_W'(irs_pkg::NPAR_E8 - 1);
    assign total   = parity_mode_reg ? {depth_eff, 5'b0} : {1'b0, depth_eff, 4'b0};

    // handshake
    assign acc      = s_tvalid && s_tready;
    assign is_pull  = (s_tuser[0] == irs_pkg::MODE_PULL);
    assign data_acc = acc && !is_pull;
    assign pull_acc = acc && is_pull && draining_reg;
    assign fresh    = draining_reg;

    // lane and count for a data byte; data during drain starts a new frame
    always_comb begin
        if (fresh || ({1'b0, lane_index_reg} >= depth_eff)) begin
            lane_cur = '0;
        end else begin
            lane_cur = lane_index_reg;
        end
        lane_inc     = {1'b0, lane_cur} + 4'd1;
        lane_nxt_val = (lane_inc >= depth_eff) ? '0 : lane_inc[LW-1:0];
        dcount_base  = fresh ? '0 : data_count_reg;
        dcount_new   = (dcount_base == irs_pkg::DCOUNT_MAX) ? dcount_base
                                                          : dcount_base + 1'b1;
    end

    // data_count mod d, kept for every possible depth d
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            dc_base = fresh ? '0 : dc_r_reg[i];
            if (dcount_base == irs_pkg::DCOUNT_MAX) begin
                dc_r_new[i] = dc_base;
            end else if (dc_base == LW'(i)) begin
                dc_r_new[i] = '0;
            end else begin
                dc_r_new[i] = dc_base + 1'b1;
            end
        end
    end

    // error code of a data byte
    assign too_long = dcount_new > irs_pkg::frame_limit(depth_eff, parity_mode_reg);
    assign not_mult = s_tlast && (dc_r_new[dsel] != '0);
    always_comb begin
        if (too_long) begin
            data_err = irs_pkg::ERR_TOO_LONG;
        end else if (not_mult) begin
            data_err = irs_pkg::ERR_NOT_MULT;
        end else begin
            data_err = irs_pkg::ERR_OK;
        end
    end

    // drain position: lane = count mod depth, parity index = count / depth
    assign drain_ext = {1'b0, drain_count_reg};
    assign sat       = drain_ext >= total;
    assign last      = sat || ((drain_ext + 9'd1) == total);
    assign rd_lane   = sat ? dsel : dr_r_reg[dsel];
    assign rd_j      = sat ? npar_m1 : dr_q_reg[dsel][irs_pkg::PIDX_W-1:0];

    // chain control
    assign cell_ctrl.upd  = data_acc;
    assign cell_ctrl.clr  = (data_acc && fresh) || (pull_acc && last);
    assign cell_ctrl.lane = is_pull ? rd_lane : lane_cur;
    assign fb = s_tdata ^ (fresh ? 8'h00 : cell_rd[0]);

    // neighbor wiring, coefficients and enables along the chain
    always_comb begin
        for (int j = 0; j < NP - 1; j++) begin
            if (j == irs_pkg::NPAR_E8 - 1 && !parity_mode_reg) begin
                cell_nbr[j] = '0;
            end else begin
                cell_nbr[j] = cell_rd[j+1];
            end
        end
        cell_nbr[NP-1] = '0;
        for (int j = 0; j < NP; j++) begin
            cell_coef[j] = parity_mode_reg ? irs_pkg::COEF_E16[j] : irs_pkg::COEF_E8[j];
            cell_en[j]   = (j < irs_pkg::NPAR_E8) || parity_mode_reg;
        end
    end

    // parity chain
    for (genvar j = 0; j < NP; j++) begin : g_cell
        irs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .en      (cell_en[j]),
            .fb      (fb),
            .coef    (cell_coef[j]),
            .nbr     (cell_nbr[j]),
            .rd      (cell_rd[j])
        );
    end

    // result of the accepted item
    always_comb begin
        if (!is_pull) begin
            res_in.out_byte   = s_tdata;
            res_in.is_parity  = 1'b0;
            res_in.block_end  = 1'b0;
            res_in.error_code = data_err;
        end else if (draining_reg) begin
            res_in.out_byte   = cell_rd[rd_j];
            res_in.is_parity  = 1'b1;
            res_in.block_end  = last;
            res_in.error_code = irs_pkg::ERR_OK;
        end else begin
            res_in.out_byte   = '0;
            res_in.is_parity  = 1'b0;
            res_in.block_end  = 1'b0;
            res_in.error_code = irs_pkg::ERR_EMPTY;
        end
    end

    // frame state next values
    always_comb begin
        lane_index_next  = lane_index_reg;
        data_count_next  = data_count_reg;
        drain_count_next = drain_count_reg;
        draining_next    = draining_reg;
        for (int i = 0; i < ND; i++) begin
            dc_r_next[i] = dc_r_reg[i];
            dr_r_next[i] = dr_r_reg[i];
            dr_q_next[i] = dr_q_reg[i];
        end
        if (data_acc) begin
            lane_index_next  = lane_nxt_val;
            data_count_next  = dcount_new;
            draining_next    = s_tlast;
            drain_count_next = '0;
            for (int i = 0; i < ND; i++) begin
                dc_r_next[i] = dc_r_new[i];
                dr_r_next[i] = '0;
                dr_q_next[i] = '0;
            end
        end else if (pull_acc) begin
            if (last) begin
                lane_index_next  = '0;
                data_count_next  = '0;
                drain_count_next = '0;
                draining_next    = 1'b0;
                for (int i = 0; i < ND; i++) begin
                    dc_r_next[i] = '0;
                    dr_r_next[i] = '0;
                    dr_q_next[i] = '0;
                end
            end else begin
                drain_count_next = drain_count_reg + 1'b1;
                for (int i = 0; i < ND; i++) begin
                    if (dr_r_reg[i] == LW'(i)) begin
                        dr_r_next[i] = '0;
                        dr_q_next[i] = dr_q_reg[i] + 1'b1;
                    end else begin
                        dr_r_next[i] = dr_r_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    // state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_mode_reg <= 1'b1;
            depth_cfg_reg   <= 4'd1;
            lane_index_reg  <= '0;
            data_count_reg  <= '0;
            drain_count_reg <= '0;
            draining_reg    <= 1'b0;
            for (int i = 0; i < ND; i++) begin
                dc_r_reg[i] <= '0;
                dr_r_reg[i] <= '0;
                dr_q_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == irs_pkg::REG_PARITY_MODE) begin
                    parity_mode_reg <= cfg_data[0];
                end else if (cfg_index == irs_pkg::REG_DEPTH) begin
                    depth_cfg_reg <= cfg_data[3:0];
                end
            end
            lane_index_reg  <= lane_index_next;
            data_count_reg  <= data_count_next;
            drain_count_reg <= drain_count_next;
            draining_reg    <= draining_next;
            for (int i = 0; i < ND; i++) begin
                dc_r_reg[i] <= dc_r_next[i];
                dr_r_reg[i] <= dr_r_next[i];
                dr_q_reg[i] <= dr_q_next[i];
            end
        end
    end

    // output stage
    irs_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (acc),
        .in_res    (res_in),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (res_out),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, res_out.error_code, res_out.out_byte};
    assign m_tuser = res_out.is_parity;
    assign m_tlast = res_out.block_end;

    // checks
    `IRS_ASSERT(a_parity_ok, m_tvalid && m_tuser[0] |-> m_tdata[9:8] == irs_pkg::ERR_OK, "parity item with error code")
    `IRS_ASSERT_NEVER(a_end_on_parity, m_tvalid && m_tlast && !m_tuser[0], "block end on a non-parity item")
    `IRS_ASSERT(a_drain_clears, pull_acc && last |=> !draining_reg && data_count_reg == '0 && lane_index_reg == '0, "frame not cleared after last parity")
    `IRS_ASSERT(a_frame_end_arms, data_acc && s_tlast |=> draining_reg && drain_count_reg == '0, "frame end did not start drain")

endmodule

// ----- tb/sv/irs_checker.sv -----
`timescale 1ns / 1ps
// channel monitor, encoder predictor and result comparison for the interleaved rs encoder
module irs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        s_tlast,   // frame_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] error_code
    input  logic [0:0]  m_tuser,   // [0] is_parity
    input  logic        m_tlast,   // block_end
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          n_items,
    output int          n_parity,
    output int          n_blocks,
    output int          n_too_long,
    output int          n_not_mult,
    output int          n_empty
);
    import irs_pkg::*;

    // generator polynomials, index 0 for 16 parity bytes, 1 for 32
    logic [7:0] gen_coef [0:1][0:MAX_PARITY];

    // predictor state
    logic [7:0] par_bank [0:MAX_DEPTH-1][0:MAX_PARITY-1];
    int         lane_sel;
    int         byte_cnt;
    int         drain_pos;
    logic       in_drain;
    logic       mode_cfg;
    logic [3:0] depth_cfg;

    result_t    awaited_out [$];

    // gf(256) product, msb-first horner form, x^8 = 0x87
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h87 : 8'h00);
            if (b[i]) acc = acc ^ a;
        end
        return acc;
    endfunction

    function automatic logic [7:0] alpha_pow(input int e);
        logic [7:0] v;
        v = 8'h01;
        for (int i = 0; i < e; i++) v = gf_times(v, 8'h02);
        return v;
    endfunction

    // product of (x + root) over the consecutive roots
    initial begin : build_generators
        int         nr;
        int         first_root;
        logic [7:0] root;
        for (int m = 0; m < 2; m++) begin
            nr = m ? NPAR_E16 : NPAR_E8;
            first_root = ROOT_CENTER - nr / 2;
            for (int k = 0; k <= MAX_PARITY; k++) gen_coef[m][k] = 8'h00;
            gen_coef[m][0] = 8'h01;
            for (int i = 0; i < nr; i++) begin
                root = alpha_pow((ROOT_STEP * (first_root + i)) % CODE_N);
                for (int k = i + 1; k >= 1; k--)
                    gen_coef[m][k] = gen_coef[m][k-1] ^ gf_times(gen_coef[m][k], root);
                gen_coef[m][0] = gf_times(gen_coef[m][0], root);
            end
        end
    end

    task automatic wipe_frame();
        for (int l = 0; l < MAX_DEPTH; l++)
            for (int j = 0; j < MAX_PARITY; j++) par_bank[l][j] = 8'h00;
        lane_sel  = 0;
        byte_cnt  = 0;
        drain_pos = 0;
        in_drain  = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // one accepted input item -> the result it must produce
    task automatic encode_item(input logic kind, input logic [7:0] din, input logic fend);
        int         dep;
        int         nr;
        int         total;
        int         ln;
        int         col;
        logic [7:0] fb;
        result_t    r;
        dep = (depth_cfg == 0) ? 1 : ((depth_cfg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_cfg));
        nr  = mode_cfg ? NPAR_E16 : NPAR_E8;
        r.out_byte   = 8'h00;
        r.is_parity  = 1'b0;
        r.block_end  = 1'b0;
        r.error_code = ERR_OK;
        if (kind == MODE_DATA) begin
            // a data item during drain abandons the pending parity
            if (in_drain) wipe_frame();
            if (lane_sel >= dep) lane_sel = 0;
            fb = din ^ par_bank[lane_sel][0];
            for (int j = 0; j + 1 < nr; j++)
                par_bank[lane_sel][j] = par_bank[lane_sel][j+1] ^
                                        gf_times(fb, gen_coef[mode_cfg][nr-1-j]);
            par_bank[lane_sel][nr-1] = gf_times(fb, gen_coef[mode_cfg][0]);
            lane_sel = (lane_sel + 1 >= dep) ? 0 : lane_sel + 1;
            if (byte_cnt < 2047) byte_cnt++;
            if (byte_cnt > dep * (CODE_N - nr)) r.error_code = ERR_TOO_LONG;
            if (fend) begin
                if (r.error_code == ERR_OK && (byte_cnt % dep) != 0)
                    r.error_code = ERR_NOT_MULT;
                in_drain  = 1'b1;
                drain_pos = 0;
            end
            r.out_byte = din;
        end else if (!in_drain) begin
            r.error_code = ERR_EMPTY;
        end else begin
            // parity j of every lane, then j+1
            total = dep * nr;
            if (drain_pos >= total) drain_pos = total - 1;
            ln  = drain_pos % dep;
            col = drain_pos / dep;
            r.out_byte  = par_bank[ln][col];
            r.is_parity = 1'b1;
            r.block_end = (drain_pos + 1 == total);
            if (r.block_end) wipe_frame();
            else drain_pos++;
        end
        n_items++;
        if (r.is_parity) n_parity++;
        if (r.block_end) n_blocks++;
        if (r.error_code == ERR_TOO_LONG) n_too_long++;
        if (r.error_code == ERR_NOT_MULT) n_not_mult++;
        if (r.error_code == ERR_EMPTY) n_empty++;
        awaited_out.push_back(r);
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
        n_items    = 0;
        n_parity   = 0;
        n_blocks   = 0;
        n_too_long = 0;
        n_not_mult = 0;
        n_empty    = 0;
    end

    // input prediction under the settings before this edge, config writes, then comparison
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            wipe_frame();
            mode_cfg  = 1'b1;
            depth_cfg = 4'd1;
            awaited_out.delete();
        end else begin
            if (s_tvalid && s_tready)
                encode_item(s_tuser[0], s_tdata[7:0], s_tlast);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PARITY_MODE: mode_cfg = cfg_data[0];
                    REG_DEPTH:       depth_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_out.size() == 0) begin
                    note_mismatch("result with nothing awaited", m_tdata[7:0], 0);
                end else begin
                    want = awaited_out.pop_front();
                    if (m_tdata[7:0] !== want.out_byte)
                        note_mismatch("out_byte", m_tdata[7:0], want.out_byte);
                    if (m_tuser[0] !== want.is_parity)
                        note_mismatch("is_parity", m_tuser[0], want.is_parity);
                    if (m_tlast !== want.block_end)
                        note_mismatch("block_end", m_tlast, want.block_end);
                    if (m_tdata[9:8] !== want.error_code)
                        note_mismatch("error_code", m_tdata[9:8], want.error_code);
                end
            end
        end
        pending = awaited_out.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// top-level bench for the interleaved rs encoder: clock, reset, stimulus and verdict
module tb_top;
    import irs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;  // index with no register behind it
    localparam int HOLD_CYCLES = 100;
    localparam int RANDOM_ITEMS = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [3:0]  cfg_data;

    int fail_count, pending, n_items, n_parity, n_blocks, n_too_long, n_not_mult, n_empty;

    // stimulus knobs and state; the rx_ knobs are shared with the receiver process
    int   tx_gap_pct;
    int   rx_stall_pct;
    logic rx_hold_req;
    int   n_sent;
    logic cur_mode;
    logic [3:0] cur_depth;

    interleaved_rs_encoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    irs_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .n_items(n_items),
        .n_parity(n_parity), .n_blocks(n_blocks), .n_too_long(n_too_long),
        .n_not_mult(n_not_mult), .n_empty(n_empty)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    function automatic int parity_total();
        int dep;
        dep = (cur_depth == 0) ? 1 : ((cur_depth > MAX_DEPTH) ? MAX_DEPTH : int'(cur_depth));
        return dep * (cur_mode ? NPAR_E16 : NPAR_E8);
    endfunction

    // offer one item, with an occasional gap before it
    task automatic send_item(input logic kind, input logic [7:0] dbyte, input logic fend);
        @(negedge aclk);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = dbyte;
        s_tlast  = fend;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // stop offering and wait for every awaited result
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == REG_PARITY_MODE) cur_mode = val[0];
        if (idx == REG_DEPTH) cur_depth = val;
    endtask

    task automatic set_config(input logic pmode, input logic [3:0] dep);
        wait_idle();
        write_reg(REG_PARITY_MODE, {3'b000, pmode});
        write_reg(REG_DEPTH, dep);
    endtask

    task automatic send_pulls(input int count);
        for (int k = 0; k < count; k++)
            send_item(MODE_PULL, 8'($urandom), 1'($urandom));
    endtask

    // data bytes with the odd stray pull, then the parity pulls
    task automatic run_frame(input int len, input int pulls);
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 99) < 4)
                send_item(MODE_PULL, 8'($urandom), 1'($urandom));
            send_item(MODE_DATA, 8'($urandom), k == len - 1);
        end
        send_pulls(pulls);
    endtask

    initial begin : stimulus
        int dep;
        int len;
        int total;
        int pulls;
        int frames_left;
        int pick;
        logic long_done;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = MODE_DATA;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PARITY_MODE;
        cfg_data = 4'h0;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 1'b0;
        n_sent = 0;
        cur_mode = 1'b1;
        cur_depth = 4'd1;
        long_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty pull at reset settings
        send_item(MODE_PULL, 8'h00, 1'b0);
        // length not a multiple of the depth, extreme data values
        set_config(1'b0, 4'd2);
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b0);
        send_item(MODE_DATA, 8'h5A, 1'b1);
        send_pulls(2);
        // data during drain starts a fresh frame, then a pull with nothing pending
        send_item(MODE_DATA, 8'hA5, 1'b0);
        send_item(MODE_PULL, 8'hFF, 1'b1);
        // depth shrinks mid-frame so the lane wraps
        wait_idle();
        write_reg(REG_DEPTH, 4'd1);
        send_item(MODE_DATA, 8'h3C, 1'b1);
        send_pulls(1);
        // depth above range acts as the maximum, drain continues under new settings
        set_config(1'b1, 4'd15);
        send_pulls(15);
        // depth zero acts as one: drain position beyond the total ends the block
        set_config(1'b0, 4'd0);
        send_pulls(2);
        wait_idle();
        write_reg(REG_SPARE, 4'hF);

        // random frames across several settings
        frames_left = 0;
        while (n_sent < RANDOM_ITEMS) begin
            if (!long_done && n_sent > 150) begin
                // over-long frame; receiver holds off while the sender keeps offering
                set_config(1'b1, 4'd1);
                tx_gap_pct = 0;
                rx_hold_req = 1'b1;
                run_frame(226, parity_total());
                long_done = 1'b1;
                frames_left = 0;
            end
            if (frames_left == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) dep = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
                else if (pick == 1) dep = MAX_DEPTH;
                else dep = $urandom_range(1, MAX_DEPTH);
                set_config($urandom_range(0, 3) == 0, 4'(dep));
                pick = $urandom_range(0, 2);
                tx_gap_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
                pick = $urandom_range(0, 2);
                rx_stall_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
                frames_left = $urandom_range(1, 3);
            end
            dep = parity_total() / (cur_mode ? NPAR_E16 : NPAR_E8);
            total = parity_total();
            if ($urandom_range(0, 99) < 85) len = dep * $urandom_range(1, 4);
            else len = $urandom_range(1, 4 * dep);
            pick = $urandom_range(0, 9);
            if (pick == 0) pulls = $urandom_range(0, total - 1);
            else if (pick == 1) pulls = total + $urandom_range(1, 3);
            else pulls = total;
            run_frame(len, pulls);
            frames_left--;
        end

        // closing stretch with no idling on either side, short fixed geometry
        wait_idle();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        set_config(1'b0, 4'd2);
        dep = parity_total() / (cur_mode ? NPAR_E16 : NPAR_E8);
        run_frame(2 * dep, parity_total() + 1);

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("run covered %0d items: %0d parity bytes, %0d complete blocks",
                 n_items, n_parity, n_blocks);
        $display("flags seen: %0d too long, %0d length mismatch, %0d empty pull",
                 n_too_long, n_not_mult, n_empty);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
